### rtl/stream_block_segmenter_unit_defines.svh
// ---------------------------------------------------------------------------
// Assertion macros for the stream block segmenter
// Shared property forms, clocked on clk and disabled in reset.
// ---------------------------------------------------------------------------
`ifndef STREAM_BLOCK_SEGMENTER_UNIT_DEFINES_SVH
`define STREAM_BLOCK_SEGMENTER_UNIT_DEFINES_SVH

// cause in this cycle implies effect in the next cycle
`define SBS_ASSERT_NEXT(label, cause, effect) \
  label: assert property (@(posedge clk) disable iff (rst) (cause) |=> (effect)) \
    else $error("segmenter check failed: next-cycle property");

// cause implies effect in the same cycle
`define SBS_ASSERT_SAME(label, cause, effect) \
  label: assert property (@(posedge clk) disable iff (rst) (cause) |-> (effect)) \
    else $error("segmenter check failed: same-cycle property");

`endif

### rtl/sbs_pkg.sv
// ---------------------------------------------------------------------------
// sbs_pkg
// Word types, widths and register indexes of the stream block segmenter.
// ---------------------------------------------------------------------------
package sbs_pkg;

  localparam int KeyWidth     = 64;
  localparam int ScalarWidth  = 48;
  localparam int BlockWidth   = 32;
  localparam int CfgDataWidth = (ScalarWidth > BlockWidth) ? ScalarWidth : BlockWidth;
  localparam int CfgIdxWidth  = 3;
  localparam int OptWidth     = 5;

  // option_flags bit positions
  localparam int OptGap     = 0;
  localparam int OptSpan    = 1;
  localparam int OptLow     = 2;
  localparam int OptHigh    = 3;
  localparam int OptDiscard = 4;

  // grouping_mode codes
  localparam logic GroupByKey    = 1'b0;
  localparam logic GroupByScalar = 1'b1;

  typedef enum logic [CfgIdxWidth-1:0] {
    REG_GROUPING_MODE = 3'd0,
    REG_START_BLOCK   = 3'd1,
    REG_GAP_LIMIT     = 3'd2,
    REG_SPAN_LIMIT    = 3'd3,
    REG_RANGE_LOW     = 3'd4,
    REG_RANGE_HIGH    = 3'd5,
    REG_OPTION_FLAGS  = 3'd6
  } cfg_reg_t;

  typedef struct packed {
    logic [KeyWidth-1:0]           record_key;
    logic signed [ScalarWidth-1:0] scalar_value;
  } rec_word_t;

  typedef struct packed {
    logic [BlockWidth-1:0] block_number;
    logic                  keep;
  } res_word_t;

endpackage

### rtl/stream_block_segmenter_unit.sv
// ---------------------------------------------------------------------------
// stream_block_segmenter_unit
// Assigns a block number and a keep flag to each streamed record.
// ---------------------------------------------------------------------------
// Takes one record (key, signed fixed-point scalar) per cycle and returns one
// result word (block number, keep) per record, in order. Sustained rate is one
// record per clock while res_stall stays low. The record lands in an input
// register, one pass of compare/subtract logic against the running state
// (previous key, previous scalar, block's first scalar, counter) produces the
// result, and it is captured in the result register. The state update for a
// record happens in the same cycle its result is captured, so the next record
// sees it with no bubble. A stalled result holds the result register; the
// input register then holds too, and rec_stall rises only when that register
// is full and cannot drain. Config registers are written through cfg_* (always
// ready); writing start_block reloads the block counter at once. Writes are
// expected only while the block is idle. Block numbers wrap at 32 bits.
// ---------------------------------------------------------------------------
module stream_block_segmenter_unit (
  input  logic                                clk,
  input  logic                                rst,
  // record input channel
  input  logic                                rec_valid,
  output logic                                rec_stall,
  input  sbs_pkg::rec_word_t                  rec_word,
  // result output channel
  output logic                                res_valid,
  input  logic                                res_stall,
  output sbs_pkg::res_word_t                  res_word,
  // config write channel
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [sbs_pkg::CfgIdxWidth-1:0]     cfg_index,
  input  logic [sbs_pkg::CfgDataWidth-1:0]    cfg_data
);

  `include "stream_block_segmenter_unit_defines.svh"

  localparam int SW = sbs_pkg::ScalarWidth;
  localparam int BW = sbs_pkg::BlockWidth;
  localparam int KW = sbs_pkg::KeyWidth;

  // config registers; start_block lives only in the counter it reloads
  logic                          grouping_mode;
  logic [SW-1:0]                 gap_limit;
  logic [SW-1:0]                 span_limit;
  logic signed [SW-1:0]          range_low;
  logic signed [SW-1:0]          range_high;
  logic [sbs_pkg::OptWidth-1:0]  option_flags;

  // running state
  logic [KW-1:0]                 previous_key;
  logic signed [SW-1:0]          previous_scalar;
  logic signed [SW-1:0]          block_first_scalar;
  logic [BW-1:0]                 block_counter;
  logic [BW-1:0]                 block_counter_next;
  logic                          previous_in_range;
  logic                          seen_first;

  // input register
  logic                          s1_valid;
  sbs_pkg::rec_word_t            s1_word;

  // datapath
  logic                          advance;
  logic                          cfg_write;
  logic signed [SW-1:0]          v;
  logic signed [SW-1:0]          prev_eff;
  logic signed [SW-1:0]          first_eff;
  logic signed [SW:0]            gap_diff;
  logic signed [SW:0]            span_diff;
  logic [SW-1:0]                 gap_abs;
  logic [SW-1:0]                 span_abs;
  logic                          gap_on, span_on, low_on, high_on, discard;
  logic                          in_bounds;
  logic                          rise;
  logic                          keep;
  logic                          load_first;
  sbs_pkg::res_word_t            res_next;

  assign cfg_ready = 1'b1;
  assign cfg_write = cfg_valid && cfg_ready;

  // input register drains whenever the result register is free or being taken
  assign advance   = s1_valid && (!res_valid || !res_stall);
  assign rec_stall = s1_valid && !advance;

  assign gap_on  = option_flags[sbs_pkg::OptGap];
  assign span_on = option_flags[sbs_pkg::OptSpan];
  assign low_on  = option_flags[sbs_pkg::OptLow];
  assign high_on = option_flags[sbs_pkg::OptHigh];
  assign discard = option_flags[sbs_pkg::OptDiscard];

  assign v = s1_word.scalar_value;

  // before the first record, the reference scalars are the record itself
  assign prev_eff  = seen_first ? previous_scalar    : v;
  assign first_eff = seen_first ? block_first_scalar : v;

  // distances never exceed 2^SW-1, so the magnitude fits in SW bits
  assign gap_diff  = {prev_eff[SW-1], prev_eff} - {v[SW-1], v};
  assign span_diff = {first_eff[SW-1], first_eff} - {v[SW-1], v};
  assign gap_abs   = gap_diff[SW]  ? SW'(~gap_diff  + 1'b1) : gap_diff[SW-1:0];
  assign span_abs  = span_diff[SW] ? SW'(~span_diff + 1'b1) : span_diff[SW-1:0];

  // inverted bounds are left as is: nothing passes with both bounds on
  assign in_bounds = (!low_on  || (v >= range_low)) &&
                     (!high_on || (v <= range_high));

  always_comb begin
    rise       = 1'b0;
    keep       = 1'b1;
    load_first = !seen_first;
    if (grouping_mode == sbs_pkg::GroupByKey) begin
      rise = seen_first && (s1_word.record_key != previous_key);
    end else if (gap_on || span_on) begin
      // no first-record guard here: a zero limit also rises on the first record
      rise = (gap_on  && (gap_abs  >= gap_limit)) ||
             (span_on && (span_abs >= span_limit));
      if (rise) begin
        load_first = 1'b1;
      end
    end else begin
      if (seen_first) begin
        if (discard) begin
          rise = previous_in_range && !in_bounds;
        end else begin
          rise = previous_in_range != in_bounds;
        end
      end
      keep = in_bounds || !discard;
    end
  end

  always_comb begin
    block_counter_next = block_counter;
    if (cfg_write && (sbs_pkg::cfg_reg_t'(cfg_index) == sbs_pkg::REG_START_BLOCK)) begin
      block_counter_next = cfg_data[BW-1:0];
    end else if (advance && rise) begin
      block_counter_next = block_counter + BW'(1);
    end
  end

  always_comb begin
    res_next.block_number = rise ? (block_counter + BW'(1)) : block_counter;
    res_next.keep         = keep;
  end

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      grouping_mode <= 1'b0;
      gap_limit     <= '0;
      span_limit    <= '0;
      range_low     <= '0;
      range_high    <= '0;
      option_flags  <= '0;
    end else if (cfg_write) begin
      case (sbs_pkg::cfg_reg_t'(cfg_index))
        sbs_pkg::REG_GROUPING_MODE: grouping_mode <= cfg_data[0];
        sbs_pkg::REG_START_BLOCK:   ;  // loads block_counter directly
        sbs_pkg::REG_GAP_LIMIT:     gap_limit     <= cfg_data[SW-1:0];
        sbs_pkg::REG_SPAN_LIMIT:    span_limit    <= cfg_data[SW-1:0];
        sbs_pkg::REG_RANGE_LOW:     range_low     <= cfg_data[SW-1:0];
        sbs_pkg::REG_RANGE_HIGH:    range_high    <= cfg_data[SW-1:0];
        sbs_pkg::REG_OPTION_FLAGS:  option_flags  <= cfg_data[sbs_pkg::OptWidth-1:0];
        default: ;
      endcase
    end
  end

  // running state, updated as each record passes into the result register
  always_ff @(posedge clk) begin
    if (rst) begin
      previous_key       <= '0;
      previous_scalar    <= '0;
      block_first_scalar <= '0;
      block_counter      <= '0;
      previous_in_range  <= 1'b0;
      seen_first         <= 1'b0;
    end else begin
      block_counter <= block_counter_next;
      if (advance) begin
        previous_key      <= s1_word.record_key;
        previous_scalar   <= v;
        previous_in_range <= in_bounds;
        seen_first        <= 1'b1;
        if (load_first) begin
          block_first_scalar <= v;
        end
      end
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (rec_valid && !rec_stall) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rec_valid && !rec_stall) begin
      s1_word <= rec_word;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (advance) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_word <= res_next;
    end
  end

  // start_block write reloads the counter on the next edge
  `SBS_ASSERT_NEXT(a_start_reload,
    cfg_write && (sbs_pkg::cfg_reg_t'(cfg_index) == sbs_pkg::REG_START_BLOCK),
    block_counter == $past(cfg_data[BW-1:0]))
  // a full, blocked pipeline holds the pending record
  `SBS_ASSERT_NEXT(a_s1_hold, s1_valid && res_valid && res_stall,
    s1_valid && $stable(s1_word))
  // a captured result always reports the counter it left behind
  `SBS_ASSERT_NEXT(a_result_counter, advance && !cfg_write,
    res_valid && (res_word.block_number == block_counter) && seen_first)

endmodule
